// File: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, action codes and controller/datapath signal bundles.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Default screen geometry in character cells.
   localparam int SCREEN_WIDTH  = 80;
   localparam int SCREEN_HEIGHT = 25;

   // Field widths of the channels.
   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = CHAR_W + ATTR_W;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   // Special characters.
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   // Attribute in force after reset.
   localparam logic [ATTR_W-1:0] COLOR_RESET = 8'h02;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;       // an input transaction completes this cycle
      logic exec;         // apply the captured item
      logic copy;         // one step of the scroll copy sweep
      logic fill;         // one step of a blank fill sweep
      logic reset_color;  // fill with the reset attribute
      logic load_rsp;     // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_fill;    // item clears the screen
      logic need_scroll;  // item scrolls the store
      logic copy_last;    // sweep counter is at the last copied cell
      logic fill_last;    // sweep counter is at the last cell
      logic rsp_free;     // result register can take a new result
   } status_type;

endpackage

// File: hdl/tcw_intf.sv
// ----------------------------------------------------------------------------
// Text console writer channel interfaces
// Request, response and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// Request channel: one item per transaction.
interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::ACTION_W-1:0]  action;
   logic [tcw_pkg::CHAR_W-1:0]    char_code;
   logic [tcw_pkg::ROW_W-1:0]     read_row;
   logic [tcw_pkg::COL_W-1:0]     read_column;

   modport source  (output valid, action, char_code, read_row, read_column, input ready);
   modport sink    (input valid, action, char_code, read_row, read_column, output ready);
   modport monitor (input valid, ready, action, char_code, read_row, read_column);
endinterface

// Response channel: one result per transaction.
interface tcw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::ROW_W-1:0]   cursor_row;
   logic [tcw_pkg::COL_W-1:0]   cursor_column;
   logic [tcw_pkg::CELL_W-1:0]  cell_value;
   logic                        scrolled;

   modport source  (output valid, cursor_row, cursor_column, cell_value, scrolled,
                    input ready);
   modport sink    (input valid, cursor_row, cursor_column, cell_value, scrolled,
                    output ready);
   modport monitor (input valid, ready, cursor_row, cursor_column, cell_value, scrolled);
endinterface

// Register-write channel for the text attribute.
interface tcw_csr_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::ATTR_W-1:0]  text_color;

   modport source  (output valid, text_color, input ready);
   modport sink    (input valid, text_color, output ready);
   modport monitor (input valid, ready, text_color);
endinterface

// File: hdl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the reset clearing pass, item execution, scroll and fill sweeps.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output tcw_pkg::cmd_type     cmd,
   input  tcw_pkg::status_type  stat
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_FILL,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      req_ready       = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.fill        = 1'b1;
            cmd.reset_color = 1'b1;
            if (stat.fill_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.need_fill) begin
               state_in = ST_FILL;
            end else if (stat.need_scroll) begin
               state_in = ST_COPY;
            end else if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (stat.copy_last) state_in = ST_FILL;
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (stat.fill_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Text store memory, cursor, attribute register, sweep counter and result.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tcw_pkg::cmd_type              cmd,
   output tcw_pkg::status_type           stat,
   input  logic [tcw_pkg::ACTION_W-1:0]  req_action,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]     req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]     req_read_column,
   input  logic                          csr_valid,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_text_color,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [tcw_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]     rsp_cursor_column,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_cell_value,
   output logic                          rsp_scrolled
);

   localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int COPY_N = SCREEN_WIDTH * (SCREEN_HEIGHT - 1);
   localparam int AW     = $clog2(DEPTH);
   localparam int RW     = ($clog2(SCREEN_HEIGHT + 1) > tcw_pkg::ROW_W) ?
                           $clog2(SCREEN_HEIGHT + 1) : tcw_pkg::ROW_W;
   localparam int CW     = ($clog2(SCREEN_WIDTH + 1) > tcw_pkg::COL_W) ?
                           $clog2(SCREEN_WIDTH + 1) : tcw_pkg::COL_W;

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW-1:0] COPY_LAST = AW'(COPY_N - 1);
   localparam logic [AW-1:0] ROW_STEP  = AW'(SCREEN_WIDTH);
   localparam logic [AW-1:0] SRC_AHEAD = AW'(SCREEN_WIDTH + 1);
   localparam logic [RW-1:0] NUM_ROWS  = RW'(SCREEN_HEIGHT);
   localparam logic [RW-1:0] LAST_ROW  = RW'(SCREEN_HEIGHT - 1);
   localparam logic [CW-1:0] NUM_COLS  = CW'(SCREEN_WIDTH);
   localparam logic [CW-1:0] LAST_COL  = CW'(SCREEN_WIDTH - 1);

   localparam logic [tcw_pkg::CELL_W-1:0] RESET_BLANK = {tcw_pkg::COLOR_RESET,
                                                          tcw_pkg::CH_SPACE};

   // Text store.
   logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tcw_pkg::CELL_W-1:0] rdata_ff;

   // Attribute, captured item and cursor.
   logic [tcw_pkg::ATTR_W-1:0]   color_ff;
   logic [tcw_pkg::ACTION_W-1:0] action_ff;
   logic [tcw_pkg::CHAR_W-1:0]   char_ff;
   logic                         rd_ok_ff;
   logic [RW-1:0]                row_ff;
   logic [RW-1:0]                row_in;
   logic [CW-1:0]                col_ff;
   logic [CW-1:0]                col_in;
   logic [AW-1:0]                addr_ff;
   logic [tcw_pkg::CELL_W-1:0]   cell_hold_ff;
   logic [tcw_pkg::CELL_W-1:0]   cell_in;
   logic                         scrolled_ff;
   logic                         scrolled_in;
   logic                         rsp_valid_ff;

   // Execution helpers.
   logic [RW-1:0]                wr_row;
   logic [CW-1:0]                wr_col;
   logic [tcw_pkg::CELL_W-1:0]   wr_cell;
   logic                         wr_en;
   logic                         fill_in;
   logic [tcw_pkg::CELL_W-1:0]   blank;
   logic [AW-1:0]                cur_addr;
   logic [RW-1:0]                req_row_ext;
   logic [CW-1:0]                req_col_ext;
   logic                         req_in_range;
   logic [AW-1:0]                req_addr;

   // Memory port controls.
   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
   logic                         mem_re;
   logic [AW-1:0]                mem_raddr;

   assign blank = {color_ff, tcw_pkg::CH_SPACE};

   // Read address of an incoming read item.
   assign req_row_ext  = RW'(req_read_row);
   assign req_col_ext  = CW'(req_read_column);
   assign req_in_range = (req_row_ext < NUM_ROWS) && (req_col_ext < NUM_COLS);
   assign req_addr     = AW'(req_row_ext) * ROW_STEP + AW'(req_col_ext);

   // Effect of the captured item on cursor and store.
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      wr_row      = row_ff;
      wr_col      = col_ff;
      wr_cell     = {color_ff, char_ff};
      wr_en       = 1'b0;
      scrolled_in = 1'b0;
      fill_in     = 1'b0;
      cell_in     = '0;
      unique case (action_ff)
         tcw_pkg::ACT_PUT: begin
            if (char_ff == tcw_pkg::CH_NEWLINE) begin
               col_in = '0;
               if (row_ff >= LAST_ROW) begin
                  scrolled_in = 1'b1;
                  row_in      = LAST_ROW;
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end else if (char_ff == tcw_pkg::CH_BACKSPACE) begin
               if (col_ff != '0) begin
                  col_in = col_ff - CW'(1);
               end else if (row_ff != '0) begin
                  row_in = row_ff - RW'(1);
                  col_in = LAST_COL;
               end
               wr_row  = row_in;
               wr_col  = col_in;
               wr_cell = blank;
               wr_en   = 1'b1;
            end else begin
               wr_en = 1'b1;
               if (col_ff >= LAST_COL) begin
                  col_in = '0;
                  if (row_ff >= LAST_ROW) begin
                     scrolled_in = 1'b1;
                     row_in      = LAST_ROW;
                  end else begin
                     row_in = row_ff + RW'(1);
                  end
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
         end
         tcw_pkg::ACT_CLEAR: begin
            fill_in = 1'b1;
            row_in  = '0;
            col_in  = '0;
         end
         tcw_pkg::ACT_READ: begin
            cell_in = rd_ok_ff ? rdata_ff : '0;
         end
         default: begin
         end
      endcase
   end

   assign cur_addr = AW'(wr_row) * ROW_STEP + AW'(wr_col);

   // Memory write port: item write, scroll copy or blank fill.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = rdata_ff;
      if (cmd.exec) begin
         mem_we    = wr_en;
         mem_waddr = cur_addr;
         mem_wdata = wr_cell;
      end else if (cmd.copy) begin
         mem_we = 1'b1;
      end else if (cmd.fill) begin
         mem_we    = 1'b1;
         mem_wdata = cmd.reset_color ? RESET_BLANK : blank;
      end
   end

   // Memory read port: item read, then the scroll source one row ahead.
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = addr_ff + SRC_AHEAD;
      if (cmd.accept) begin
         mem_re    = req_in_range;
         mem_raddr = req_addr;
      end else if (cmd.exec) begin
         mem_re    = 1'b1;
         mem_raddr = ROW_STEP;
      end else if (cmd.copy) begin
         mem_re = (addr_ff != COPY_LAST);
      end
   end

   // Text store with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   // Item capture and held result fields.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req_action;
         char_ff   <= req_char_code;
         rd_ok_ff  <= req_in_range;
      end
      if (cmd.exec) begin
         cell_hold_ff <= cell_in;
         scrolled_ff  <= scrolled_in;
      end
   end

   // Cursor, attribute and sweep counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         color_ff <= tcw_pkg::COLOR_RESET;
         addr_ff  <= '0;
      end else begin
         if (cmd.exec) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (csr_valid) color_ff <= csr_text_color;
         if (cmd.exec) begin
            addr_ff <= '0;
         end else if (cmd.copy || cmd.fill) begin
            addr_ff <= (addr_ff == LAST_ADDR) ? '0 : addr_ff + AW'(1);
         end
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload: fresh values during execution, held values afterward.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (cmd.exec) begin
            rsp_cursor_row    <= row_in[tcw_pkg::ROW_W-1:0];
            rsp_cursor_column <= col_in[tcw_pkg::COL_W-1:0];
            rsp_cell_value    <= cell_in;
            rsp_scrolled      <= scrolled_in;
         end else begin
            rsp_cursor_row    <= row_ff[tcw_pkg::ROW_W-1:0];
            rsp_cursor_column <= col_ff[tcw_pkg::COL_W-1:0];
            rsp_cell_value    <= cell_hold_ff;
            rsp_scrolled      <= scrolled_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Status toward the controller.
   assign stat.need_fill   = fill_in;
   assign stat.need_scroll = scrolled_in;
   assign stat.copy_last   = (addr_ff == COPY_LAST);
   assign stat.fill_last   = (addr_ff == LAST_ADDR);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

endmodule

// File: hdl/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// Text console writer top level
// Character terminal over a text store of attribute/character cells.
// ----------------------------------------------------------------------------
// Put and read items pass the item capture register, then the result register; a
// new request is taken only back in idle. One item is in work at a time.
// A scroll runs a copy sweep, then a blank row fill, and a clear runs a fill sweep;
// both sweeps are set by the single write port of the text store. After reset a
// clearing pass runs with req ready low; register writes are taken.
module text_console_writer_top #(
   parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT
) (
   input logic        clock,
   input logic        reset,
   tcw_req_if.sink    req_if,
   tcw_rsp_if.source  rsp_if,
   tcw_csr_if.sink    csr_if
);

   tcw_pkg::cmd_type    cmd;
   tcw_pkg::status_type stat;

   // The attribute register takes a write in any cycle out of reset.
   assign csr_if.ready = 1'b1;

   // Controller.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Datapath.
   tcw_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_if.action),
      .req_char_code     (req_if.char_code),
      .req_read_row      (req_if.read_row),
      .req_read_column   (req_if.read_column),
      .csr_valid         (csr_if.valid),
      .csr_text_color    (csr_if.text_color),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_cursor_row    (rsp_if.cursor_row),
      .rsp_cursor_column (rsp_if.cursor_column),
      .rsp_cell_value    (rsp_if.cell_value),
      .rsp_scrolled      (rsp_if.scrolled)
   );

endmodule

// File: hdl/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
module tcw_checker #(
   parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   input logic [tcw_pkg::COL_W-1:0]   rsp_cursor_column,
   input logic                        rsp_scrolled
);

   // A stalled result keeps its valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // The clearing pass holds off requests right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request accepted during the clearing pass");

   // Only one item is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted while an item is in work");

   // The reported cursor always lies on the screen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_row) < SCREEN_HEIGHT) &&
                    (32'(rsp_cursor_column) < SCREEN_WIDTH))
      else $error("cursor outside the screen");

   // A scroll leaves the cursor at the start of the last row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |->
         (rsp_cursor_column == '0) &&
         (32'(rsp_cursor_row) == SCREEN_HEIGHT - 1))
      else $error("scroll left the cursor off the last row start");

endmodule

bind text_console_writer_top tcw_checker #(
   .SCREEN_WIDTH  (SCREEN_WIDTH),
   .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tcw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_cursor_row    (rsp_if.cursor_row),
   .rsp_cursor_column (rsp_if.cursor_column),
   .rsp_scrolled      (rsp_if.scrolled)
);
